// ===== hw/rtl/mlt_pkg.sv =====
// shared types, constants and keyword tables for the tokenizer
package mlt_pkg;

   localparam int LINE_BITS_DEF   = 16;
   localparam int COLUMN_BITS_DEF = 12;
   localparam int LENGTH_BITS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int KIND_BITS = 6;
   localparam int KW_COUNT  = 25;

   localparam logic [KIND_BITS-1:0] K_END   = 6'd0;
   localparam logic [KIND_BITS-1:0] K_ERR   = 6'd1;
   localparam logic [KIND_BITS-1:0] K_NUM   = 6'd2;
   localparam logic [KIND_BITS-1:0] K_IDENT = 6'd3;
   localparam logic [KIND_BITS-1:0] K_KW0   = 6'd16;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_CR   = 3'd1,
      MODE_NOTE = 3'd2,
      MODE_NUM  = 3'd3,
      MODE_WORD = 3'd4
   } mode_type;

   typedef logic [KW_COUNT-1:0] kw_mask_type;

   // keyword text, first character in the highest used byte
   localparam logic [159:0] KW_TEXT [KW_COUNT] = '{
      160'("TITLE"), 160'("NEURON"), 160'("UNITS"), 160'("PARAMETER"),
      160'("ASSIGNED"), 160'("STATE"), 160'("BREAKPOINT"), 160'("DERIVATIVE"),
      160'("PROCEDURE"), 160'("INITIAL"), 160'("UNITSOFF"), 160'("UNITSON"),
      160'("SUFFIX"), 160'({"NONSPECIFIC", "_CURRENT"}), 160'("USEION"), 160'("READ"),
      160'("WRITE"), 160'("RANGE"), 160'("LOCAL"), 160'("SOLVE"),
      160'("THREADSAFE"), 160'("GLOBAL"), 160'("METHOD"), 160'("if"), 160'("else")
   };

   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd5, 5'd6, 5'd5, 5'd9, 5'd8, 5'd5, 5'd10, 5'd10, 5'd9, 5'd7, 5'd8, 5'd7,
      5'd6, 5'd19, 5'd6, 5'd4, 5'd5, 5'd5, 5'd5, 5'd5, 5'd10, 5'd6, 5'd6,
      5'd2, 5'd4
   };

   function automatic logic kw_char_hit(input int k, input logic [4:0] pos,
                                        input logic [7:0] b);
      logic [4:0] idx;
      idx = KW_LEN[k] - 5'd1 - pos;
      return KW_TEXT[k][{idx, 3'b000} +: 8] == b;
   endfunction

endpackage

// ===== hw/rtl/model_language_tokenizer.sv =====
// top level of the streaming source tokenizer
//
// input channel req_: one source byte per word, byte 0 marks end of input
// output channel rsp_: one token word (kind, start line, start column,
//   length, last_of_run); a byte yields zero, one or two token words,
//   last_of_run marks the final one of that byte
// the scanner takes one byte per cycle while req_stall is low; a token
//   is written into a four-entry queue when the byte that completes it is
//   taken, and then passes an output register on its way to rsp_
// output drains one token per cycle while rsp_stall is low, so bytes that
//   yield two tokens can fill the queue faster than it drains
// req_stall rises when the queue has fewer than two free entries
// rsp_stall holds the output word; the queue absorbs tokens until req_stall rises
// synchronous reset returns to line 1 column 1, no pending token,
//   no sticky error, empty queue
module model_language_tokenizer import mlt_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF,
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_source_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KIND_BITS-1:0]   rsp_token_kind,
   output logic [LINE_BITS-1:0]   rsp_start_line,
   output logic [COLUMN_BITS-1:0] rsp_start_column,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic                   rsp_last_of_run
);

   localparam int WIDTH = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1;

   logic                              step, full2, q_valid, q_take;
   logic [1:0]                        rec_count;
   logic [1:0][KIND_BITS-1:0]         rec_kind;
   logic [1:0][LINE_BITS-1:0]         rec_line;
   logic [1:0][COLUMN_BITS-1:0]       rec_column;
   logic [1:0][LENGTH_BITS-1:0]       rec_length;
   logic [1:0]                        rec_last;
   logic [1:0][WIDTH-1:0]             wr_data;
   logic [WIDTH-1:0]                  q_data, out_data;

   assign req_stall = full2;
   assign step      = req_valid && !full2;

   mlt_front #(
      .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock, .reset, .step, .byte_in(req_source_byte),
      .rec_count, .rec_kind, .rec_line, .rec_column, .rec_length, .rec_last
   );

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         wr_data[i] = {rec_kind[i], rec_line[i], rec_column[i], rec_length[i], rec_last[i]};
      end
   end

   mlt_queue #(.WIDTH(WIDTH), .DEPTH(QUEUE_DEPTH_DEF)) u_queue (
      .clock, .reset, .wr_count(step ? rec_count : 2'd0), .wr_data,
      .full2, .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
   );

   mlt_back #(.WIDTH(WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_data, .q_take,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data
   );

   assign {rsp_token_kind, rsp_start_line, rsp_start_column, rsp_token_length,
           rsp_last_of_run} = out_data;

endmodule

// ===== hw/rtl/mlt_front.sv =====
// front end: scans source bytes and builds up to two token records per byte
module mlt_front import mlt_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF,
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [7:0]                        byte_in,
   output logic [1:0]                        rec_count,
   output logic [1:0][KIND_BITS-1:0]         rec_kind,
   output logic [1:0][LINE_BITS-1:0]         rec_line,
   output logic [1:0][COLUMN_BITS-1:0]       rec_column,
   output logic [1:0][LENGTH_BITS-1:0]       rec_length,
   output logic [1:0]                        rec_last
);

   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] run_ff, run_in;
   logic [1:0]             point_ff, point_in;
   kw_mask_type            cand_ff, cand_in;
   logic                   sticky_ff, sticky_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, tline_ff, tline_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, tcol_ff, tcol_in;

   logic                   a_valid, b_valid, skip;
   logic [KIND_BITS-1:0]   a_kind, b_kind;
   logic [LINE_BITS-1:0]   a_line, b_line;
   logic [COLUMN_BITS-1:0] a_col, b_col;
   logic [LENGTH_BITS-1:0] a_len, b_len;

   logic is_digit, is_letter, is_blank, is_op, ends_common, is_word_ch;
   logic [KIND_BITS-1:0] punct;

   function automatic kw_mask_type narrow(input kw_mask_type cand,
                                          input logic [LENGTH_BITS-1:0] rl,
                                          input logic [7:0] b);
      kw_mask_type r;
      r = cand;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (rl >= LENGTH_BITS'(KW_LEN[k]) || !kw_char_hit(k, rl[4:0], b)) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [KIND_BITS-1:0] word_kind(input kw_mask_type cand,
                                                      input logic [LENGTH_BITS-1:0] rl);
      logic [KIND_BITS-1:0] r;
      r = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && rl == LENGTH_BITS'(KW_LEN[k])) begin
            r = K_KW0 + KIND_BITS'(k);
         end
      end
      return r;
   endfunction

   always_comb begin
      is_digit   = byte_in >= "0" && byte_in <= "9";
      is_letter  = (byte_in >= "a" && byte_in <= "z") || (byte_in >= "A" && byte_in <= "Z");
      is_blank   = byte_in == 8'h20 || byte_in == 8'h09 || byte_in == 8'h0B ||
                   byte_in == 8'h0C;
      is_op      = byte_in == "+" || byte_in == "-" || byte_in == "*" || byte_in == "/" ||
                   byte_in == "^" || byte_in == "'";
      ends_common = byte_in == 8'h00 || is_blank || byte_in == 8'h0A || byte_in == 8'h0D ||
                    is_op || byte_in == ")" || byte_in == "," || byte_in == ":" ||
                    byte_in == "}";
      is_word_ch = is_digit || is_letter || byte_in == "_";
      unique case (byte_in)
         "=":     punct = 6'd4;
         "+":     punct = 6'd5;
         "-":     punct = 6'd6;
         "*":     punct = 6'd7;
         "/":     punct = 6'd8;
         "^":     punct = 6'd9;
         ",":     punct = 6'd10;
         "'":     punct = 6'd11;
         "{":     punct = 6'd12;
         "}":     punct = 6'd13;
         "(":     punct = 6'd14;
         ")":     punct = 6'd15;
         default: punct = K_END;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      run_in    = run_ff;
      point_in  = point_ff;
      cand_in   = cand_ff;
      sticky_in = sticky_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      a_valid = 1'b0; a_kind = K_END; a_line = tline_ff; a_col = tcol_ff; a_len = '0;
      b_valid = 1'b0; b_kind = K_END; b_line = line_ff; b_col = col_ff; b_len = '0;
      skip = 1'b0;

      unique case (mode_ff)
         MODE_CR: begin
            mode_in = MODE_IDLE;
            if (byte_in == 8'h0A) begin
               if (line_in != '1) line_in = line_in + 1'b1;
               col_in = COLUMN_BITS'(1);
               skip = 1'b1;
            end else begin
               sticky_in = 1'b1;
               a_valid = 1'b1;
               a_kind = K_ERR;
            end
         end
         MODE_NOTE: begin
            if (byte_in != 8'h0A && byte_in != 8'h00) begin
               if (col_in != '1) col_in = col_in + 1'b1;
               skip = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit || byte_in == ".") begin
               if (byte_in == "." && point_in != 2'd3) point_in = point_in + 2'd1;
               if (run_in != '1) run_in = run_in + 1'b1;
               if (col_in != '1) col_in = col_in + 1'b1;
               skip = 1'b1;
            end else begin
               if (!ends_common) begin
                  if (run_in != '1) run_in = run_in + 1'b1;
                  sticky_in = 1'b1;
               end
               if (point_in > 2'd1) sticky_in = 1'b1;
               a_valid = 1'b1;
               a_kind = sticky_in ? K_ERR : K_NUM;
               a_len = run_in;
            end
         end
         MODE_WORD: begin
            if (is_word_ch) begin
               cand_in = narrow(cand_ff, run_ff, byte_in);
               if (run_in != '1) run_in = run_in + 1'b1;
               if (col_in != '1) col_in = col_in + 1'b1;
               skip = 1'b1;
            end else begin
               if (!(ends_common || byte_in == "(" || byte_in == "{" || byte_in == "=")) begin
                  if (run_in != '1) run_in = run_in + 1'b1;
                  sticky_in = 1'b1;
               end
               a_valid = 1'b1;
               a_kind = sticky_in ? K_ERR : word_kind(cand_ff, run_in);
               a_len = run_in;
            end
         end
         default: ;
      endcase

      if (!skip) begin
         mode_in = MODE_IDLE;
         priority if (byte_in == 8'h00) begin
            b_valid = 1'b1;
            b_kind = K_END;
         end else if (is_blank) begin
            if (col_in != '1) col_in = col_in + 1'b1;
         end else if (byte_in == 8'h0A) begin
            if (line_in != '1) line_in = line_in + 1'b1;
            col_in = COLUMN_BITS'(1);
         end else if (byte_in == 8'h0D) begin
            tline_in = line_in;
            tcol_in = col_in;
            if (col_in != '1) col_in = col_in + 1'b1;
            mode_in = MODE_CR;
         end else if (byte_in == ":") begin
            if (col_in != '1) col_in = col_in + 1'b1;
            mode_in = MODE_NOTE;
         end else if (is_digit || byte_in == ".") begin
            tline_in = line_in;
            tcol_in = col_in;
            run_in = LENGTH_BITS'(1);
            point_in = (byte_in == ".") ? 2'd1 : 2'd0;
            if (col_in != '1) col_in = col_in + 1'b1;
            mode_in = MODE_NUM;
         end else if (is_letter || byte_in == "_") begin
            tline_in = line_in;
            tcol_in = col_in;
            cand_in = narrow('1, '0, byte_in);
            run_in = LENGTH_BITS'(1);
            if (col_in != '1) col_in = col_in + 1'b1;
            mode_in = MODE_WORD;
         end else if (punct != K_END) begin
            b_valid = 1'b1;
            b_kind = punct;
            b_len = LENGTH_BITS'(1);
            if (col_in != '1) col_in = col_in + 1'b1;
         end else begin
            sticky_in = 1'b1;
            b_valid = 1'b1;
            b_kind = K_ERR;
            b_len = LENGTH_BITS'(1);
            if (col_in != '1) col_in = col_in + 1'b1;
         end
         b_line = line_ff;
         b_col = col_ff;
         if (mode_ff == MODE_NOTE || mode_ff == MODE_CR) begin
            b_line = line_ff;
            b_col = col_ff;
         end
      end
   end

   // position of an idle-lexed record is the position before this byte's own step
   always_comb begin
      rec_count  = {1'b0, a_valid} + {1'b0, b_valid};
      rec_kind   = '0;
      rec_line   = '0;
      rec_column = '0;
      rec_length = '0;
      rec_last   = 2'b00;
      if (a_valid) begin
         rec_kind[0] = a_kind; rec_line[0] = a_line;
         rec_column[0] = a_col; rec_length[0] = a_len; rec_last[0] = !b_valid;
         rec_kind[1] = b_kind; rec_line[1] = b_line;
         rec_column[1] = b_col; rec_length[1] = b_len; rec_last[1] = 1'b1;
      end else begin
         rec_kind[0] = b_kind; rec_line[0] = b_line;
         rec_column[0] = b_col; rec_length[0] = b_len; rec_last[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         run_ff    <= '0;
         point_ff  <= '0;
         cand_ff   <= '1;
         sticky_ff <= 1'b0;
         line_ff   <= LINE_BITS'(1);
         col_ff    <= COLUMN_BITS'(1);
         tline_ff  <= LINE_BITS'(1);
         tcol_ff   <= COLUMN_BITS'(1);
      end else if (step) begin
         mode_ff   <= mode_in;
         run_ff    <= run_in;
         point_ff  <= point_in;
         cand_ff   <= cand_in;
         sticky_ff <= sticky_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
      end
   end

endmodule

// ===== hw/rtl/mlt_queue.sv =====
// token queue: up to two writes and one read per cycle
module mlt_queue import mlt_pkg::*; #(
   parameter int WIDTH = 44,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            wr_count,
   input  logic [1:0][WIDTH-1:0] wr_data,
   output logic                  full2,
   output logic                  rd_valid,
   input  logic                  rd_take,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]    mem [DEPTH];
   logic [PTR_BITS-1:0] wp_ff, rp_ff;
   logic [PTR_BITS:0]   cnt_ff;
   logic                pop;

   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem[rp_ff];
   assign pop      = rd_valid && rd_take;
   assign full2    = cnt_ff > (PTR_BITS+1)'(DEPTH - 2);

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) mem[wp_ff] <= wr_data[0];
      if (wr_count == 2'd2) mem[wp_ff + 1'b1] <= wr_data[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + PTR_BITS'(wr_count);
         rp_ff  <= rp_ff + PTR_BITS'(pop);
         cnt_ff <= cnt_ff + (PTR_BITS+1)'(wr_count) - (PTR_BITS+1)'(pop);
      end
   end

endmodule

// ===== hw/rtl/mlt_back.sv =====
// back end: output register for token words
module mlt_back import mlt_pkg::*; #(
   parameter int WIDTH = 44
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  logic [WIDTH-1:0] q_data,
   output logic             q_take,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic [WIDTH-1:0] data_ff;
   logic             load;

   assign load      = !valid_ff || !out_stall;
   assign q_take    = load;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && q_valid) data_ff <= q_data;
   end

endmodule

// ===== verif/testbench.sv =====
// testbench for the streaming source tokenizer: directed and random source text against a predictor
`timescale 1ns / 100ps

module testbench;
   import mlt_pkg::*;

   localparam int LB = LINE_BITS_DEF;
   localparam int CB = COLUMN_BITS_DEF;
   localparam int NB = LENGTH_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [LB-1:0]        line;
      logic [CB-1:0]        column;
      logic [NB-1:0]        length;
      logic                 last;
   } token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_source_byte = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [KIND_BITS-1:0] rsp_token_kind;
   logic [LB-1:0] rsp_start_line;
   logic [CB-1:0] rsp_start_column;
   logic [NB-1:0] rsp_token_length;
   logic rsp_last_of_run;

   model_language_tokenizer DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   token_type expected_tokens[$];
   int errors = 0;
   int cycles = 0;
   int hold_cycles = 0;
   bit hold_start = 1'b0;
   bit rsp_idle_on = 1'b1;

   // predictor state
   mode_type    lx_mode;
   logic [NB-1:0] lx_len;
   logic [1:0]  lx_points;
   kw_mask_type lx_cand;
   logic        lx_sticky;
   logic [LB-1:0] lx_line, lx_tline;
   logic [CB-1:0] lx_col, lx_tcol;
   token_type   lx_out[$];

   string kw_words[KW_COUNT] = '{"TITLE", "NEURON", "UNITS", "PARAMETER", "ASSIGNED",
      "STATE", "BREAKPOINT", "DERIVATIVE", "PROCEDURE", "INITIAL", "UNITSOFF",
      "UNITSON", "SUFFIX", string'({"NONSPECIFIC", "_CURRENT"}), "USEION", "READ", "WRITE",
      "RANGE", "LOCAL", "SOLVE", "THREADSAFE", "GLOBAL", "METHOD", "if", "else"};

   string punct_chars = "=+-*/^,'{}()";

   function automatic bit is_digit(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
   function automatic bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction
   function automatic bit is_blank(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C;
   endfunction
   function automatic bit is_op(logic [7:0] b);
      return b == "+" || b == "-" || b == "*" || b == "/" || b == "^" || b == 8'h27;
   endfunction
   function automatic bit is_term(logic [7:0] b);
      return b == 0 || is_blank(b) || b == 8'h0A || b == 8'h0D || is_op(b) ||
             b == ")" || b == "," || b == ":" || b == "}";
   endfunction
   function automatic logic [KIND_BITS-1:0] punct_of(logic [7:0] b);
      case (b)
         "=": return 6'd4;
         "+": return 6'd5;
         "-": return 6'd6;
         "*": return 6'd7;
         "/": return 6'd8;
         "^": return 6'd9;
         ",": return 6'd10;
         8'h27: return 6'd11;
         "{": return 6'd12;
         "}": return 6'd13;
         "(": return 6'd14;
         ")": return 6'd15;
         default: return 6'd0;
      endcase
   endfunction

   task automatic push_token(logic [KIND_BITS-1:0] k, logic [LB-1:0] l, logic [CB-1:0] c,
                             logic [NB-1:0] n);
      token_type t;
      t = '{k, l, c, n, 1'b0};
      lx_out.push_back(t);
   endtask

   task automatic col_up; if (lx_col != '1) lx_col++; endtask
   task automatic len_up; if (lx_len != '1) lx_len++; endtask
   task automatic line_up;
      if (lx_line != '1) lx_line++;
      lx_col = 1;
   endtask

   task automatic narrow_cand(logic [7:0] b);
      for (int k = 0; k < KW_COUNT; k++)
         if (lx_cand[k] && (lx_len >= kw_words[k].len() || kw_words[k][lx_len] != b))
            lx_cand[k] = 1'b0;
   endtask

   function automatic logic [KIND_BITS-1:0] word_of();
      for (int k = 0; k < KW_COUNT; k++)
         if (lx_cand[k] && lx_len == kw_words[k].len()) return K_KW0 + k;
      return K_IDENT;
   endfunction

   task automatic lexer_reset;
      lx_mode = MODE_IDLE; lx_len = 0; lx_points = 0; lx_cand = '1; lx_sticky = 0;
      lx_line = 1; lx_col = 1; lx_tline = 1; lx_tcol = 1;
   endtask

   task automatic predict_tokens(logic [7:0] b);
      logic [KIND_BITS-1:0] pk;
      bit done;
      done = 0;
      lx_out.delete();
      case (lx_mode)
         MODE_CR: begin
            lx_mode = MODE_IDLE;
            if (b == 8'h0A) begin
               line_up(); done = 1;
            end else begin
               lx_sticky = 1; push_token(K_ERR, lx_tline, lx_tcol, 0);
            end
         end
         MODE_NOTE: begin
            if (b != 8'h0A && b != 0) begin
               col_up(); done = 1;
            end
         end
         MODE_NUM: begin
            if (is_digit(b) || b == ".") begin
               if (b == "." && lx_points < 3) lx_points++;
               len_up(); col_up(); done = 1;
            end else begin
               if (!is_term(b)) begin
                  len_up(); lx_sticky = 1;
               end
               if (lx_points > 1) lx_sticky = 1;
               push_token(lx_sticky ? K_ERR : K_NUM, lx_tline, lx_tcol, lx_len);
            end
         end
         MODE_WORD: begin
            if (is_digit(b) || is_letter(b) || b == "_") begin
               narrow_cand(b); len_up(); col_up(); done = 1;
            end else begin
               if (!(is_term(b) || b == "(" || b == "{" || b == "=")) begin
                  len_up(); lx_sticky = 1;
               end
               push_token(lx_sticky ? K_ERR : word_of(), lx_tline, lx_tcol, lx_len);
            end
         end
         default: ;
      endcase
      if (!done) begin
         lx_mode = MODE_IDLE;
         pk = punct_of(b);
         if (b == 0) push_token(K_END, lx_line, lx_col, 0);
         else if (is_blank(b)) col_up();
         else if (b == 8'h0A) line_up();
         else if (b == 8'h0D) begin
            lx_tline = lx_line; lx_tcol = lx_col; col_up(); lx_mode = MODE_CR;
         end else if (b == ":") begin
            col_up(); lx_mode = MODE_NOTE;
         end else if (is_digit(b) || b == ".") begin
            lx_tline = lx_line; lx_tcol = lx_col; lx_len = 1;
            lx_points = (b == ".") ? 2'd1 : 2'd0; col_up(); lx_mode = MODE_NUM;
         end else if (is_letter(b) || b == "_") begin
            lx_tline = lx_line; lx_tcol = lx_col; lx_cand = '1; lx_len = 0;
            narrow_cand(b); lx_len = 1; col_up(); lx_mode = MODE_WORD;
         end else if (pk != 0) begin
            push_token(pk, lx_line, lx_col, 1); col_up();
         end else begin
            lx_sticky = 1; push_token(K_ERR, lx_line, lx_col, 1); col_up();
         end
      end
      if (lx_out.size() > 0) lx_out[lx_out.size()-1].last = 1'b1;
      foreach (lx_out[i]) expected_tokens.push_back(lx_out[i]);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int short_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   bit send_idle_on = 1'b1;

   task automatic send_byte(logic [7:0] b);
      int g;
      g = send_idle_on ? short_gap() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // result checker
   always @(posedge clock) begin
      token_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token kind", rsp_token_kind, -1);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_token_kind != want.kind) report_mismatch("kind", rsp_token_kind, want.kind);
            if (rsp_start_line != want.line) report_mismatch("line", rsp_start_line, want.line);
            if (rsp_start_column != want.column)
               report_mismatch("column", rsp_start_column, want.column);
            if (rsp_token_length != want.length)
               report_mismatch("length", rsp_token_length, want.length);
            if (rsp_last_of_run != want.last) report_mismatch("last", rsp_last_of_run, want.last);
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_cycles <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_on) begin
         if ($urandom_range(0, 49) == 0) hold_cycles <= $urandom_range(5, 30);
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else rsp_stall <= 1'b0;
   end

   task automatic test_directed;
      send_text("TITLE NEURON UNITS PARAMETER ASSIGNED STATE BREAKPOINT DERIVATIVE\n");
      send_text("PROCEDURE INITIAL UNITSOFF UNITSON SUFFIX NONSPECIFIC");
      send_text("_CURRENT USEION\n");
      send_text("READ WRITE RANGE LOCAL SOLVE THREADSAFE GLOBAL METHOD if else IF x_9\n");
      send_text("=+-*/^,'{}() 12.5 .7: comment\r\x0b\n\t3.4.5 a(b{c=d)\r\n");
      send_text("\x0c12a x$ 1\r7 ok\xff");
      send_byte(8'h00);
      send_text("\x80 after 9 z");
      send_byte(8'h00);
   endtask

   task automatic test_saturation;
      repeat (300) send_byte("a");
      send_byte(" ");
      send_text("q1 ");
      send_byte(8'h00);
   endtask

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 255);
         1, 2: return "a" + $urandom_range(0, 25);
         3: return "0" + $urandom_range(0, 9);
         4: return " ";
         5: return 8'h0A;
         6: return ".";
         7: return punct_chars[$urandom_range(0, 11)];
         8: return ":";
         default: return ($urandom_range(0, 1)) ? 8'h0D : "_";
      endcase
   endfunction

   task automatic test_random(int count);
      int sent;
      int pick;
      int n;
      string w;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            w = kw_words[$urandom_range(0, KW_COUNT-1)];
            send_text(w);
            send_byte(random_char());
            sent += w.len() + 1;
         end else if (pick < 6) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte("0" + $urandom_range(0, 9));
            if ($urandom_range(0, 1)) begin
               send_byte(".");
               n++;
            end
            send_byte("0" + $urandom_range(0, 9));
            send_byte(random_char());
            sent += n + 2;
         end else if (pick == 6) begin
            send_text("\r\n");
            sent += 2;
         end else if (pick == 7 && $urandom_range(0, 9) == 0) begin
            send_byte(8'h00);
            sent += 1;
         end else begin
            send_byte(random_char());
            sent += 1;
         end
      end
   endtask

   task automatic test_backpressure;
      hold_start = 1'b1;
      send_idle_on = 1'b0;
      repeat (40) send_text("+x ");
      send_idle_on = 1'b1;
   endtask

   initial begin
      lexer_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      rsp_idle_on = 1'b0;
      test_random(300);
      rsp_idle_on = 1'b1;
      test_random(700);
      test_saturation();
      send_byte(8'h00);
      req_valid <= 1'b0;
      while (expected_tokens.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
